>>> rtl/bra_pkg.sv
// Shared types, codes and defaults of the banker's resource allocator.
package bra_pkg;

   localparam int DEF_PROCESSES  = 8;
   localparam int DEF_RESOURCES  = 4;
   localparam int DEF_COUNT_BITS = 8;
   localparam int AMT_W          = 8;
   localparam int PID_W          = 3;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 8;

   typedef enum logic [1:0] {
      OP_SET_MAX = 2'd0,
      OP_REQUEST = 2'd1,
      OP_RELEASE = 2'd2,
      OP_DETECT  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACT_PROC = 3'd0,
      CSR_ACT_RES  = 3'd1,
      CSR_AVOID    = 3'd2,
      CSR_TOTAL0   = 3'd3,
      CSR_TOTAL1   = 3'd4,
      CSR_TOTAL2   = 3'd5,
      CSR_TOTAL3   = 3'd6
   } csr_type;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_WAIT   = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   localparam logic [1:0] WAIT_NONE = 2'd0;
   localparam logic [1:0] WAIT_RES  = 2'd1;
   localparam logic [1:0] WAIT_SAFE = 2'd2;

   typedef struct packed {
      op_type           op;
      logic [PID_W-1:0] proc_id;
      logic [AMT_W-1:0] amount0;
      logic [AMT_W-1:0] amount1;
      logic [AMT_W-1:0] amount2;
      logic [AMT_W-1:0] amount3;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             woke_valid;
      logic [PID_W-1:0] woke_proc;
      logic             woke_granted;
      logic [3:0]       deadlock_count;
      logic [7:0]       deadlock_mask;
   } rsp_type;

endpackage

>>> rtl/bankers_resource_allocator.sv
// Banker's resource allocator: sequencer, state tables and shared scan unit.
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/req_stall | bra_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall | bra_pkg::rsp_type
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// Set max and plain requests go straight from S_EXEC to S_DONE.
// Safety and detection scans check one process per cycle, in passes over the
// P active processes until all have finished or a pass makes no progress. A
// release may start one scan per waiting process it examines.
// Reset is synchronous and clears all tables; free counts start at zero.
// A finished word waits in the output register under rsp_stall while the
// next word is accepted; csr_ready is always high.
module bankers_resource_allocator #(
   parameter int PROCESSES  = bra_pkg::DEF_PROCESSES,
   parameter int RESOURCES  = bra_pkg::DEF_RESOURCES,
   parameter int COUNT_BITS = bra_pkg::DEF_COUNT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bra_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output bra_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bra_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bra_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int IW  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam int PCW = $clog2(PROCESSES + 1);
   localparam int RW  = $clog2(RESOURCES + 1);
   localparam int CW  = COUNT_BITS;
   localparam int WW  = COUNT_BITS + 6;
   localparam int EW  = (COUNT_BITS > bra_pkg::AMT_W) ? COUNT_BITS : bra_pkg::AMT_W;
   localparam logic [CW-1:0] CMAX = {CW{1'b1}};

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_EXEC = 6'b000010,
      S_WSEL = 6'b000100,
      S_SCAN = 6'b001000,
      S_FIN  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   typedef logic [CW-1:0] row_type [RESOURCES];

   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CW] ? CMAX : s[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
      return (a > b) ? (a - b) : '0;
   endfunction

   function automatic logic [CW-1:0] sat_amt(input logic [bra_pkg::AMT_W-1:0] a);
      return (EW'(a) > EW'(CMAX)) ? CMAX : CW'(a);
   endfunction

   // registers
   state_type                 st_ff, st_in;
   bra_pkg::op_type           op_ff, op_in;
   logic [bra_pkg::PID_W-1:0] pid_ff, pid_in;
   logic [bra_pkg::AMT_W-1:0] amt_ff [RESOURCES];
   logic [bra_pkg::AMT_W-1:0] amt_in [RESOURCES];
   logic [3:0]                ap_ff, ap_in;
   logic [2:0]                ar_ff, ar_in;
   logic                      avoid_ff, avoid_in;
   logic [bra_pkg::AMT_W-1:0] total_ff [RESOURCES];
   logic [bra_pkg::AMT_W-1:0] total_in [RESOURCES];
   logic [CW-1:0]             free_ff [RESOURCES];
   logic [CW-1:0]             free_in [RESOURCES];
   row_type                   need_ff [PROCESSES];
   row_type                   need_in [PROCESSES];
   row_type                   alloc_ff [PROCESSES];
   row_type                   alloc_in [PROCESSES];
   row_type                   pend_ff [PROCESSES];
   row_type                   pend_in [PROCESSES];
   logic [1:0]                wait_ff [PROCESSES];
   logic [1:0]                wait_in [PROCESSES];
   logic [WW-1:0]             work_ff [RESOURCES];
   logic [WW-1:0]             work_in [RESOURCES];
   logic [PROCESSES-1:0]      done_ff, done_in;
   logic                      prog_ff, prog_in;
   logic [IW-1:0]             i_ff, i_in;
   logic [IW-1:0]             w_ff, w_in;
   logic [IW-1:0]             cand_p_ff, cand_p_in;
   logic [CW-1:0]             cand_amt_ff [RESOURCES];
   logic [CW-1:0]             cand_amt_in [RESOURCES];
   logic                      cand_kind1_ff, cand_kind1_in;
   bra_pkg::rsp_type          res_ff, res_in;
   bra_pkg::rsp_type          rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // combinational helpers
   logic [PCW-1:0]       np;
   logic [RW-1:0]        nr;
   logic [RESOURCES-1:0] res_on;
   logic [PROCESSES-1:0] act;
   logic [IW-1:0]        pid_idx;
   logic                 pid_ok;
   logic [IW-1:0]        rd_idx;
   row_type              need_row, alloc_row, pend_row;
   logic [CW-1:0]        amt_c [RESOURCES];
   logic [CW-1:0]        g_amt [RESOURCES];
   logic [CW-1:0]        cmp_v [RESOURCES];
   logic [bra_pkg::AMT_W-1:0] raw_amt [4];
   logic                 le_total, le_need, le_alloc, fits_amt, fits_pend;
   logic                 sel_adj, row_ok, last_i, last_w, all_done, scan_safe;
   logic [PROCESSES-1:0] done_nx;
   logic                 prog_nx;
   logic [7:0]           dmask8;
   logic [PCW-1:0]       dcount;
   logic                 det;

   // clamp the active counts
   always_comb begin
      if (ap_ff == 4'd0)
         np = PCW'(1);
      else if (32'(ap_ff) > PROCESSES)
         np = PCW'(PROCESSES);
      else
         np = PCW'(ap_ff);
      if (ar_ff == 3'd0)
         nr = RW'(1);
      else if (32'(ar_ff) > RESOURCES)
         nr = RW'(RESOURCES);
      else
         nr = RW'(ar_ff);
      for (int r = 0; r < RESOURCES; r++) res_on[r] = (32'(r) < 32'(nr));
      for (int p = 0; p < PROCESSES; p++) act[p] = (32'(p) < 32'(np));
   end

   assign pid_idx = IW'(pid_ff);
   assign pid_ok  = 32'(pid_ff) < 32'(np);
   assign det     = (op_ff == bra_pkg::OP_DETECT);
   assign last_i  = 32'(i_ff) == 32'(np) - 32'd1;
   assign last_w  = 32'(w_ff) == 32'(np) - 32'd1;

   // select the table row read this cycle
   always_comb begin
      if (st_ff == S_EXEC)
         rd_idx = pid_idx;
      else if (st_ff == S_WSEL)
         rd_idx = w_ff;
      else if (st_ff == S_SCAN)
         rd_idx = i_ff;
      else
         rd_idx = cand_p_ff;
   end

   assign need_row  = need_ff[rd_idx];
   assign alloc_row = alloc_ff[rd_idx];
   assign pend_row  = pend_ff[rd_idx];

   // per-resource compares, grant amounts and one scan step
   always_comb begin
      raw_amt[0] = req_data.amount0;
      raw_amt[1] = req_data.amount1;
      raw_amt[2] = req_data.amount2;
      raw_amt[3] = req_data.amount3;
      le_total  = 1'b1;
      le_need   = 1'b1;
      le_alloc  = 1'b1;
      fits_amt  = 1'b1;
      fits_pend = 1'b1;
      row_ok    = !done_ff[i_ff];
      sel_adj   = !det && (i_ff == cand_p_ff);
      for (int r = 0; r < RESOURCES; r++) begin
         amt_c[r] = sat_amt(amt_ff[r]);
         if (st_ff == S_EXEC)
            g_amt[r] = amt_c[r];
         else if (st_ff == S_WSEL)
            g_amt[r] = pend_row[r];
         else
            g_amt[r] = cand_amt_ff[r];
         if (det)
            cmp_v[r] = pend_row[r];
         else if (sel_adj)
            cmp_v[r] = sat_sub(need_row[r], cand_amt_ff[r]);
         else
            cmp_v[r] = need_row[r];
         if (res_on[r]) begin
            if (amt_ff[r] > total_ff[r]) le_total = 1'b0;
            if (EW'(amt_ff[r]) > EW'(need_row[r])) le_need = 1'b0;
            if (EW'(amt_ff[r]) > EW'(alloc_row[r])) le_alloc = 1'b0;
            if (EW'(amt_ff[r]) > EW'(free_ff[r])) fits_amt = 1'b0;
            if (pend_row[r] > free_ff[r]) fits_pend = 1'b0;
            if (WW'(cmp_v[r]) > work_ff[r]) row_ok = 1'b0;
         end
      end
      done_nx = done_ff;
      done_nx[i_ff] = done_ff[i_ff] | row_ok;
      prog_nx  = prog_ff | row_ok;
      all_done = &(done_nx | ~act);
      scan_safe = &(done_ff | ~act);
      dmask8 = '0;
      dcount = '0;
      for (int p = 0; p < PROCESSES; p++) begin
         if (act[p] && !done_ff[p]) begin
            dcount = dcount + PCW'(1);
            if (p < 8) dmask8[p] = 1'b1;
         end
      end
   end

   // next state
   always_comb begin
      st_in         = st_ff;
      op_in         = op_ff;
      pid_in        = pid_ff;
      amt_in        = amt_ff;
      ap_in         = ap_ff;
      ar_in         = ar_ff;
      avoid_in      = avoid_ff;
      total_in      = total_ff;
      free_in       = free_ff;
      need_in       = need_ff;
      alloc_in      = alloc_ff;
      pend_in       = pend_ff;
      wait_in       = wait_ff;
      work_in       = work_ff;
      done_in       = done_ff;
      prog_in       = prog_ff;
      i_in          = i_ff;
      w_in          = w_ff;
      cand_p_in     = cand_p_ff;
      cand_amt_in   = cand_amt_ff;
      cand_kind1_in = cand_kind1_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;

      // drop the output word once taken
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      // register writes
      if (csr_valid) begin
         unique case (csr_index) inside
            bra_pkg::CSR_ACT_PROC: ap_in = csr_data[3:0];
            bra_pkg::CSR_ACT_RES:  ar_in = csr_data[2:0];
            bra_pkg::CSR_AVOID:    avoid_in = csr_data[0];
            bra_pkg::CSR_TOTAL0, bra_pkg::CSR_TOTAL1,
            bra_pkg::CSR_TOTAL2, bra_pkg::CSR_TOTAL3: begin
               for (int r = 0; r < RESOURCES; r++) begin
                  if (32'(csr_index) == 32'(bra_pkg::CSR_TOTAL0) + 32'(r)) begin
                     total_in[r] = csr_data;
                     free_in[r]  = sat_amt(csr_data);
                  end
               end
            end
            default: ;
         endcase
      end

      unique case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_data.op;
               pid_in = req_data.proc_id;
               for (int r = 0; r < RESOURCES; r++) amt_in[r] = raw_amt[r];
               res_in = '0;
               st_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            st_in = S_DONE;
            if (det) begin
               // start the detection scan from the free counts
               for (int r = 0; r < RESOURCES; r++)
                  work_in[r] = res_on[r] ? WW'(free_ff[r]) : '0;
               done_in = '0;
               prog_in = 1'b0;
               i_in    = '0;
               st_in   = S_SCAN;
            end else if (!pid_ok) begin
               res_in.status = bra_pkg::STATUS_REJECT;
            end else if (op_ff == bra_pkg::OP_SET_MAX) begin
               if (!le_total)
                  res_in.status = bra_pkg::STATUS_REJECT;
               else
                  for (int r = 0; r < RESOURCES; r++)
                     if (res_on[r]) need_in[pid_idx][r] = amt_c[r];
            end else if (op_ff == bra_pkg::OP_REQUEST) begin
               if (wait_ff[pid_idx] != bra_pkg::WAIT_NONE || !le_need) begin
                  res_in.status = bra_pkg::STATUS_REJECT;
               end else if (!fits_amt) begin
                  wait_in[pid_idx] = bra_pkg::WAIT_RES;
                  for (int r = 0; r < RESOURCES; r++)
                     pend_in[pid_idx][r] = res_on[r] ? amt_c[r] : '0;
                  res_in.status = bra_pkg::STATUS_WAIT;
               end else if (avoid_ff) begin
                  cand_p_in = pid_idx;
                  for (int r = 0; r < RESOURCES; r++) begin
                     cand_amt_in[r] = amt_c[r];
                     work_in[r] = res_on[r] ? WW'(free_ff[r] - amt_c[r]) : '0;
                  end
                  done_in = '0;
                  prog_in = 1'b0;
                  i_in    = '0;
                  st_in   = S_SCAN;
               end else begin
                  for (int r = 0; r < RESOURCES; r++) begin
                     if (res_on[r]) begin
                        need_in[pid_idx][r]  = sat_sub(need_row[r], g_amt[r]);
                        alloc_in[pid_idx][r] = sat_add(alloc_row[r], g_amt[r]);
                        free_in[r]           = sat_sub(free_ff[r], g_amt[r]);
                     end
                  end
               end
            end else begin
               if (!le_alloc) begin
                  res_in.status = bra_pkg::STATUS_REJECT;
               end else begin
                  for (int r = 0; r < RESOURCES; r++) begin
                     if (res_on[r]) begin
                        free_in[r]           = sat_add(free_ff[r], amt_c[r]);
                        alloc_in[pid_idx][r] = alloc_row[r] - amt_c[r];
                        need_in[pid_idx][r]  = sat_add(need_row[r], amt_c[r]);
                     end
                  end
                  w_in  = '0;
                  st_in = S_WSEL;
               end
            end
         end

         S_WSEL: begin
            // examine waiter w
            if ((wait_ff[w_ff] == bra_pkg::WAIT_RES && fits_pend) ||
                (wait_ff[w_ff] == bra_pkg::WAIT_SAFE && avoid_ff && fits_pend)) begin
               if (avoid_ff) begin
                  cand_kind1_in = (wait_ff[w_ff] == bra_pkg::WAIT_RES);
                  cand_p_in     = w_ff;
                  for (int r = 0; r < RESOURCES; r++) begin
                     cand_amt_in[r] = pend_row[r];
                     work_in[r] = res_on[r] ? WW'(free_ff[r] - pend_row[r]) : '0;
                  end
                  done_in = '0;
                  prog_in = 1'b0;
                  i_in    = '0;
                  st_in   = S_SCAN;
               end else begin
                  for (int r = 0; r < RESOURCES; r++) begin
                     if (res_on[r]) begin
                        need_in[w_ff][r]  = sat_sub(need_row[r], g_amt[r]);
                        alloc_in[w_ff][r] = sat_add(alloc_row[r], g_amt[r]);
                        free_in[r]        = sat_sub(free_ff[r], g_amt[r]);
                     end
                     pend_in[w_ff][r] = '0;
                  end
                  wait_in[w_ff]       = bra_pkg::WAIT_NONE;
                  res_in.woke_valid   = 1'b1;
                  res_in.woke_proc    = bra_pkg::PID_W'(w_ff);
                  res_in.woke_granted = 1'b1;
                  st_in = S_DONE;
               end
            end else if (last_w) begin
               st_in = S_DONE;
            end else begin
               w_in = w_ff + IW'(1);
            end
         end

         S_SCAN: begin
            // one process per cycle; passes repeat while progress is made
            if (row_ok) begin
               for (int r = 0; r < RESOURCES; r++)
                  work_in[r] = work_ff[r] + WW'(alloc_row[r]) +
                               (sel_adj ? WW'(cand_amt_ff[r]) : '0);
            end
            done_in = done_nx;
            prog_in = prog_nx;
            if (last_i) begin
               if (all_done || !prog_nx) begin
                  st_in = S_FIN;
               end else begin
                  i_in    = '0;
                  prog_in = 1'b0;
               end
            end else begin
               i_in = i_ff + IW'(1);
            end
         end

         S_FIN: begin
            st_in = S_DONE;
            if (det) begin
               res_in.deadlock_count = 4'(dcount);
               res_in.deadlock_mask  = dmask8;
            end else if (op_ff == bra_pkg::OP_REQUEST && !scan_safe) begin
               wait_in[cand_p_ff] = bra_pkg::WAIT_SAFE;
               for (int r = 0; r < RESOURCES; r++)
                  pend_in[cand_p_ff][r] = res_on[r] ? cand_amt_ff[r] : '0;
               res_in.status = bra_pkg::STATUS_WAIT;
            end else if (scan_safe) begin
               // grant the candidate; a woken waiter also clears its wait
               for (int r = 0; r < RESOURCES; r++) begin
                  if (res_on[r]) begin
                     need_in[cand_p_ff][r]  = sat_sub(need_row[r], g_amt[r]);
                     alloc_in[cand_p_ff][r] = sat_add(alloc_row[r], g_amt[r]);
                     free_in[r]             = sat_sub(free_ff[r], g_amt[r]);
                  end
               end
               if (op_ff == bra_pkg::OP_RELEASE) begin
                  for (int r = 0; r < RESOURCES; r++) pend_in[cand_p_ff][r] = '0;
                  wait_in[cand_p_ff]  = bra_pkg::WAIT_NONE;
                  res_in.woke_valid   = 1'b1;
                  res_in.woke_proc    = bra_pkg::PID_W'(cand_p_ff);
                  res_in.woke_granted = 1'b1;
               end
            end else if (cand_kind1_ff) begin
               wait_in[cand_p_ff] = bra_pkg::WAIT_SAFE;
               res_in.woke_valid  = 1'b1;
               res_in.woke_proc   = bra_pkg::PID_W'(cand_p_ff);
            end else if (!last_w) begin
               w_in  = w_ff + IW'(1);
               st_in = S_WSEL;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               st_in        = S_IDLE;
            end
         end

         default: st_in = S_IDLE;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         ap_ff        <= 4'd8;
         ar_ff        <= 3'd4;
         avoid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < RESOURCES; r++) begin
            total_ff[r] <= '0;
            free_ff[r]  <= '0;
         end
         for (int p = 0; p < PROCESSES; p++) begin
            wait_ff[p] <= bra_pkg::WAIT_NONE;
            for (int r = 0; r < RESOURCES; r++) begin
               need_ff[p][r]  <= '0;
               alloc_ff[p][r] <= '0;
               pend_ff[p][r]  <= '0;
            end
         end
      end else begin
         st_ff        <= st_in;
         ap_ff        <= ap_in;
         ar_ff        <= ar_in;
         avoid_ff     <= avoid_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         free_ff      <= free_in;
         wait_ff      <= wait_in;
         need_ff      <= need_in;
         alloc_ff     <= alloc_in;
         pend_ff      <= pend_in;
      end
      op_ff         <= op_in;
      pid_ff        <= pid_in;
      amt_ff        <= amt_in;
      work_ff       <= work_in;
      done_ff       <= done_in;
      prog_ff       <= prog_in;
      i_ff          <= i_in;
      w_ff          <= w_in;
      cand_p_ff     <= cand_p_in;
      cand_amt_ff   <= cand_amt_in;
      cand_kind1_ff <= cand_kind1_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall = (st_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // finished processes stay finished within a scan
   a_done_grow: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_SCAN && $past(st_ff) == S_SCAN) |->
      ((done_ff & $past(done_ff)) == $past(done_ff)))
      else $error("scan lost a finished process");

   // a scan only leaves toward its wrap-up
   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_SCAN) |=> (st_ff == S_SCAN || st_ff == S_FIN))
      else $error("scan left without wrap-up");

   // a new output word comes only from the done state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(st_ff == S_DONE))
      else $error("output word loaded outside done state");

endmodule

>>> test/testbench.sv
// Self-checking testbench of the banker's resource allocator.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NPROC       = 8;
   localparam int NRES        = 4;
   localparam int CMAX        = 255;
   localparam int STALL_LIMIT = 20000;
   localparam int RAND_PHASES = 9;
   localparam int PHASE_WORDS = 106;
   localparam int REQ_W       = $bits(bra_pkg::req_type);
   localparam logic [bra_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef logic [7:0] amt_type [NRES];

   typedef struct {
      bit                                is_csr;
      logic [bra_pkg::CSR_IDX_W-1:0]     idx;
      logic [bra_pkg::CSR_DATA_W-1:0]    val;
      bra_pkg::req_type                  w;
      bit                                typed;
      bra_pkg::rsp_type                  rsp;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bra_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bra_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [bra_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bra_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // allocator image kept by the predictor
   logic [3:0] cfg_procs = 4'd8;
   logic [2:0] cfg_res = 3'd4;
   logic       cfg_avoid = 1'b0;
   logic [7:0] total_cnt [NRES] = '{default: 8'd0};
   logic [7:0] free_cnt [NRES] = '{default: 8'd0};
   logic [7:0] need_tab [NPROC][NRES] = '{default: '{default: 8'd0}};
   logic [7:0] alloc_tab [NPROC][NRES] = '{default: '{default: 8'd0}};
   logic [7:0] pend_tab [NPROC][NRES] = '{default: '{default: 8'd0}};
   logic [1:0] wait_kind [NPROC] = '{default: bra_pkg::WAIT_NONE};

   bra_pkg::rsp_type expected_rsp [$];
   step_type plan [$];
   int errors = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   bankers_resource_allocator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int live_procs();
      int p;
      p = cfg_procs;
      if (p < 1) p = 1;
      if (p > NPROC) p = NPROC;
      return p;
   endfunction

   function automatic int live_res();
      int r;
      r = cfg_res;
      if (r < 1) r = 1;
      if (r > NRES) r = NRES;
      return r;
   endfunction

   function automatic bit fits_free(amt_type a, int nr);
      for (int r = 0; r < nr; r++)
         if (a[r] > free_cnt[r]) return 1'b0;
      return 1'b1;
   endfunction

   // banker's check on the state after granting a to process p
   function automatic bit grant_is_safe(int p, amt_type a, int np, int nr);
      int work [NRES];
      bit done [NPROC];
      int left;
      bit progress;
      bit ok;
      int nd;
      if (!fits_free(a, nr)) return 1'b0;
      for (int r = 0; r < NRES; r++) work[r] = (r < nr) ? free_cnt[r] - a[r] : 0;
      for (int i = 0; i < NPROC; i++) done[i] = 1'b0;
      left = np;
      progress = 1'b1;
      while (left > 0 && progress) begin
         progress = 1'b0;
         for (int i = 0; i < np; i++) begin
            if (done[i]) continue;
            ok = 1'b1;
            for (int r = 0; r < nr; r++) begin
               nd = need_tab[i][r];
               if (i == p) nd = (nd > a[r]) ? nd - a[r] : 0;
               if (nd > work[r]) ok = 1'b0;
            end
            if (!ok) continue;
            for (int r = 0; r < nr; r++)
               work[r] += alloc_tab[i][r] + ((i == p) ? a[r] : 0);
            done[i] = 1'b1;
            left--;
            progress = 1'b1;
         end
      end
      return left == 0;
   endfunction

   function automatic void grant_to(int p, amt_type a, int nr);
      for (int r = 0; r < nr; r++) begin
         need_tab[p][r] = (need_tab[p][r] > a[r]) ? need_tab[p][r] - a[r] : 8'd0;
         alloc_tab[p][r] = 8'((alloc_tab[p][r] + a[r] > CMAX) ? CMAX :
                              alloc_tab[p][r] + a[r]);
         free_cnt[r] = (free_cnt[r] > a[r]) ? free_cnt[r] - a[r] : 8'd0;
      end
   endfunction

   // work out the result of one accepted word and advance the image
   function automatic bra_pkg::rsp_type allocate_word(bra_pkg::req_type w);
      bra_pkg::rsp_type o;
      amt_type a;
      amt_type pend;
      int np, nr, pid, work [NRES];
      bit done [NPROC];
      bit progress, ok, wake, give;
      logic [1:0] kind;
      o = '0;
      a[0] = w.amount0; a[1] = w.amount1; a[2] = w.amount2; a[3] = w.amount3;
      np = live_procs();
      nr = live_res();
      pid = w.proc_id;
      if (w.op == bra_pkg::OP_DETECT) begin
         for (int r = 0; r < NRES; r++) work[r] = (r < nr) ? free_cnt[r] : 0;
         for (int i = 0; i < NPROC; i++) done[i] = 1'b0;
         progress = 1'b1;
         while (progress) begin
            progress = 1'b0;
            for (int i = 0; i < np; i++) begin
               if (done[i]) continue;
               ok = 1'b1;
               for (int r = 0; r < nr; r++)
                  if (pend_tab[i][r] > work[r]) ok = 1'b0;
               if (!ok) continue;
               for (int r = 0; r < nr; r++) work[r] += alloc_tab[i][r];
               done[i] = 1'b1;
               progress = 1'b1;
            end
         end
         for (int i = 0; i < np; i++)
            if (!done[i]) begin
               o.deadlock_count++;
               o.deadlock_mask[i] = 1'b1;
            end
      end else if (pid >= np) begin
         o.status = bra_pkg::STATUS_REJECT;
      end else if (w.op == bra_pkg::OP_SET_MAX) begin
         for (int r = 0; r < nr; r++)
            if (a[r] > total_cnt[r]) o.status = bra_pkg::STATUS_REJECT;
         if (o.status == bra_pkg::STATUS_OK)
            for (int r = 0; r < nr; r++) need_tab[pid][r] = a[r];
      end else if (w.op == bra_pkg::OP_REQUEST) begin
         if (wait_kind[pid] != bra_pkg::WAIT_NONE) o.status = bra_pkg::STATUS_REJECT;
         for (int r = 0; r < nr; r++)
            if (a[r] > need_tab[pid][r]) o.status = bra_pkg::STATUS_REJECT;
         if (o.status == bra_pkg::STATUS_OK) begin
            kind = bra_pkg::WAIT_NONE;
            if (!fits_free(a, nr)) kind = bra_pkg::WAIT_RES;
            else if (cfg_avoid && !grant_is_safe(pid, a, np, nr)) kind = bra_pkg::WAIT_SAFE;
            if (kind != bra_pkg::WAIT_NONE) begin
               wait_kind[pid] = kind;
               for (int r = 0; r < NRES; r++) pend_tab[pid][r] = (r < nr) ? a[r] : 8'd0;
               o.status = bra_pkg::STATUS_WAIT;
            end else begin
               grant_to(pid, a, nr);
            end
         end
      end else begin
         for (int r = 0; r < nr; r++)
            if (a[r] > alloc_tab[pid][r]) o.status = bra_pkg::STATUS_REJECT;
         if (o.status == bra_pkg::STATUS_OK) begin
            for (int r = 0; r < nr; r++) begin
               free_cnt[r] = 8'((free_cnt[r] + a[r] > CMAX) ? CMAX : free_cnt[r] + a[r]);
               alloc_tab[pid][r] = alloc_tab[pid][r] - a[r];
               need_tab[pid][r] = 8'((need_tab[pid][r] + a[r] > CMAX) ? CMAX :
                                     need_tab[pid][r] + a[r]);
            end
            // wake the first waiter whose condition now holds
            for (int i = 0; i < np; i++) begin
               for (int r = 0; r < NRES; r++) pend[r] = pend_tab[i][r];
               wake = 1'b0;
               give = 1'b0;
               if (wait_kind[i] == bra_pkg::WAIT_RES && fits_free(pend, nr)) begin
                  wake = 1'b1;
                  give = !(cfg_avoid && !grant_is_safe(i, pend, np, nr));
               end else if (wait_kind[i] == bra_pkg::WAIT_SAFE && cfg_avoid &&
                            grant_is_safe(i, pend, np, nr)) begin
                  wake = 1'b1;
                  give = 1'b1;
               end
               if (!wake) continue;
               o.woke_valid = 1'b1;
               o.woke_proc = bra_pkg::PID_W'(i);
               if (give) begin
                  grant_to(i, pend, nr);
                  for (int r = 0; r < NRES; r++) pend_tab[i][r] = 8'd0;
                  wait_kind[i] = bra_pkg::WAIT_NONE;
                  o.woke_granted = 1'b1;
               end else begin
                  wait_kind[i] = bra_pkg::WAIT_SAFE;
               end
               break;
            end
         end
      end
      return o;
   endfunction

   function automatic void apply_csr(logic [bra_pkg::CSR_IDX_W-1:0] idx, logic [7:0] val);
      unique case (idx) inside
         bra_pkg::CSR_ACT_PROC: cfg_procs = val[3:0];
         bra_pkg::CSR_ACT_RES:  cfg_res = val[2:0];
         bra_pkg::CSR_AVOID:    cfg_avoid = val[0];
         bra_pkg::CSR_TOTAL0, bra_pkg::CSR_TOTAL1,
         bra_pkg::CSR_TOTAL2, bra_pkg::CSR_TOTAL3: begin
            total_cnt[idx - bra_pkg::CSR_TOTAL0] = val;
            free_cnt[idx - bra_pkg::CSR_TOTAL0] = val;
         end
         default: ;
      endcase
   endfunction

   function automatic bra_pkg::req_type make_word(bra_pkg::op_type op, int pid,
                                                  int a0, int a1, int a2, int a3);
      bra_pkg::req_type w;
      w.op = op;
      w.proc_id = bra_pkg::PID_W'(pid);
      w.amount0 = 8'(a0); w.amount1 = 8'(a1); w.amount2 = 8'(a2); w.amount3 = 8'(a3);
      return w;
   endfunction

   function automatic void plan_word(bra_pkg::req_type w, bit typed, bra_pkg::rsp_type rsp);
      step_type s;
      s.is_csr = 1'b0;
      s.idx = '0;
      s.val = '0;
      s.w = w;
      s.typed = typed;
      s.rsp = rsp;
      plan.push_back(s);
   endfunction

   function automatic void plan_csr(logic [bra_pkg::CSR_IDX_W-1:0] idx, int val);
      step_type s;
      s = '{default: '0};
      s.is_csr = 1'b1;
      s.idx = idx;
      s.val = bra_pkg::CSR_DATA_W'(val);
      plan.push_back(s);
   endfunction

   function automatic bra_pkg::rsp_type status_only(logic [1:0] st);
      bra_pkg::rsp_type o;
      o = '0;
      o.status = st;
      return o;
   endfunction

   // well-formed words mostly, drawn from the current image; some noise
   function automatic bra_pkg::req_type random_word();
      bra_pkg::req_type w;
      amt_type a;
      int pick, pid, lim;
      pick = $urandom_range(99);
      if (pick < 8) return bra_pkg::req_type'(REQ_W'({$urandom, $urandom}));
      pid = $urandom_range(0, live_procs() - 1);
      if ($urandom_range(99) < 4) pid = $urandom_range(0, NPROC - 1);
      pick = $urandom_range(99);
      for (int r = 0; r < NRES; r++) begin
         if (pick < 20) lim = total_cnt[r];
         else if (pick < 60) lim = need_tab[pid][r];
         else lim = alloc_tab[pid][r];
         a[r] = 8'($urandom_range(0, lim));
         if ($urandom_range(99) < 5 && lim < CMAX) a[r] = 8'(lim + 1);
      end
      w = make_word(pick < 20 ? bra_pkg::OP_SET_MAX : pick < 60 ? bra_pkg::OP_REQUEST :
                    pick < 90 ? bra_pkg::OP_RELEASE : bra_pkg::OP_DETECT,
                    pid, a[0], a[1], a[2], a[3]);
      return w;
   endfunction

   task automatic write_csr(logic [bra_pkg::CSR_IDX_W-1:0] idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic send_word(bra_pkg::req_type w, bit typed, bra_pkg::rsp_type rsp);
      bra_pkg::rsp_type guess;
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      guess = allocate_word(w);
      expected_rsp.push_back(typed ? rsp : guess);
   endtask

   task automatic random_config(int procs, int res);
      int v;
      write_csr(bra_pkg::CSR_ACT_PROC, 8'(procs));
      write_csr(bra_pkg::CSR_ACT_RES, 8'(res));
      write_csr(bra_pkg::CSR_AVOID, 8'($urandom_range(0, 1)));
      for (int r = 0; r < NRES; r++) begin
         v = $urandom_range(99);
         write_csr(bra_pkg::CSR_IDX_W'(int'(bra_pkg::CSR_TOTAL0) + r),
                   8'(v < 10 ? 255 : v < 18 ? 0 : $urandom_range(1, 12)));
      end
   endtask

   // receiver backpressure
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   // compare each result word with the oldest expectation
   function automatic void check_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      bra_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("status", want.status, rsp_data.status);
            check_field("woke_valid", want.woke_valid, rsp_data.woke_valid);
            check_field("woke_proc", want.woke_proc, rsp_data.woke_proc);
            check_field("woke_granted", want.woke_granted, rsp_data.woke_granted);
            check_field("deadlock_count", want.deadlock_count, rsp_data.deadlock_count);
            check_field("deadlock_mask", want.deadlock_mask, rsp_data.deadlock_mask);
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      bra_pkg::rsp_type wake1;
      wake1 = '0;
      wake1.woke_valid = 1'b1;
      wake1.woke_proc = 3'd1;
      wake1.woke_granted = 1'b1;

      // directed steps
      plan_csr(bra_pkg::CSR_ACT_PROC, 8);
      plan_csr(bra_pkg::CSR_ACT_RES, 4);
      plan_csr(bra_pkg::CSR_AVOID, 0);
      plan_csr(bra_pkg::CSR_TOTAL0, 255);
      plan_csr(bra_pkg::CSR_TOTAL1, 10);
      plan_csr(bra_pkg::CSR_TOTAL2, 3);
      plan_csr(bra_pkg::CSR_TOTAL3, 0);
      plan_word(make_word(bra_pkg::OP_DETECT, 0, 0, 0, 0, 0), 1,
                status_only(bra_pkg::STATUS_OK));
      plan_word(make_word(bra_pkg::OP_SET_MAX, 0, 255, 10, 3, 0), 1,
                status_only(bra_pkg::STATUS_OK));
      plan_word(make_word(bra_pkg::OP_SET_MAX, 1, 0, 11, 0, 0), 1,
                status_only(bra_pkg::STATUS_REJECT));
      plan_word(make_word(bra_pkg::OP_SET_MAX, 7, 255, 255, 255, 255), 1,
                status_only(bra_pkg::STATUS_REJECT));
      plan_word(make_word(bra_pkg::OP_REQUEST, 0, 255, 10, 3, 0), 1,
                status_only(bra_pkg::STATUS_OK));
      plan_word(make_word(bra_pkg::OP_REQUEST, 1, 0, 0, 0, 0), 1,
                status_only(bra_pkg::STATUS_OK));
      plan_word(make_word(bra_pkg::OP_SET_MAX, 1, 1, 1, 1, 0), 1,
                status_only(bra_pkg::STATUS_OK));
      plan_word(make_word(bra_pkg::OP_REQUEST, 1, 1, 1, 1, 0), 1,
                status_only(bra_pkg::STATUS_WAIT));
      plan_word(make_word(bra_pkg::OP_REQUEST, 1, 0, 0, 0, 0), 1,
                status_only(bra_pkg::STATUS_REJECT));
      plan_word(make_word(bra_pkg::OP_DETECT, 7, 255, 255, 255, 255), 0, '0);
      plan_word(make_word(bra_pkg::OP_RELEASE, 0, 0, 11, 0, 0), 1,
                status_only(bra_pkg::STATUS_REJECT));
      plan_word(make_word(bra_pkg::OP_RELEASE, 0, 1, 1, 1, 0), 1, wake1);
      plan_word(make_word(bra_pkg::OP_RELEASE, 0, 254, 9, 2, 0), 1,
                status_only(bra_pkg::STATUS_OK));
      // safe-state waits with avoidance on, then left stranded with it off
      plan_csr(bra_pkg::CSR_AVOID, 1);
      plan_csr(bra_pkg::CSR_TOTAL0, 4);
      plan_word(make_word(bra_pkg::OP_SET_MAX, 3, 4, 0, 0, 0), 0, '0);
      plan_word(make_word(bra_pkg::OP_SET_MAX, 4, 4, 0, 0, 0), 0, '0);
      plan_word(make_word(bra_pkg::OP_REQUEST, 3, 2, 0, 0, 0), 0, '0);
      plan_word(make_word(bra_pkg::OP_REQUEST, 4, 2, 0, 0, 0), 0, '0);
      plan_word(make_word(bra_pkg::OP_RELEASE, 3, 2, 0, 0, 0), 0, '0);
      plan_word(make_word(bra_pkg::OP_REQUEST, 3, 4, 0, 0, 0), 0, '0);
      plan_csr(bra_pkg::CSR_AVOID, 0);
      plan_word(make_word(bra_pkg::OP_RELEASE, 4, 1, 0, 0, 0), 0, '0);
      plan_word(make_word(bra_pkg::OP_DETECT, 0, 0, 0, 0, 0), 0, '0);
      // processes out of range and register index out of range
      plan_csr(bra_pkg::CSR_ACT_PROC, 2);
      plan_word(make_word(bra_pkg::OP_REQUEST, 5, 0, 0, 0, 0), 1,
                status_only(bra_pkg::STATUS_REJECT));
      plan_csr(CSR_UNUSED, 255);
      plan_word(make_word(bra_pkg::OP_DETECT, 0, 0, 0, 0, 0), 0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[k]) begin
         if (plan[k].is_csr) begin
            req_valid <= 1'b0;
            drain();
            write_csr(plan[k].idx, plan[k].val);
         end else begin
            send_word(plan[k].w, plan[k].typed, plan[k].rsp);
         end
      end

      // random phases over settings and idling modes
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         req_valid <= 1'b0;
         drain();
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 77; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 77; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         if (ph == 0) random_config(8, 4);
         else if (ph == 1) random_config(1, 1);
         else if ($urandom_range(99) < 20)
            random_config($urandom_range(0, 15), $urandom_range(0, 7));
         else random_config($urandom_range(2, 8), $urandom_range(1, 4));
         repeat (PHASE_WORDS) send_word(random_word(), 1'b0, '0);
      end

      req_valid <= 1'b0;
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

>>> sim.f
rtl/bra_pkg.sv
rtl/bankers_resource_allocator.sv
test/testbench.sv
